### rtl/ckp_pkg.sv
// ----------------------------------------------------------------------------
// ckp_pkg
// Shared types and constants for the calculator keyboard and printer I/O block.
// ----------------------------------------------------------------------------
package ckp_pkg;

    // item kinds
    localparam logic [2:0] KIND_SHIFT  = 3'd0;
    localparam logic [2:0] KIND_PRINT  = 3'd1;
    localparam logic [2:0] KIND_TICK   = 3'd2;
    localparam logic [2:0] KIND_STATUS = 3'd3;
    localparam logic [2:0] KIND_KEYS   = 3'd4;
    localparam logic [2:0] KIND_CELL   = 3'd5;

    localparam int CKP_PRINT_LINES   = 11;
    localparam int CKP_PRINT_COLUMNS = 17;
    localparam int CKP_DRUM_STEPS    = 13;

    localparam int CKP_KEY_LINES  = 10;
    localparam int CKP_NIBBLE     = 4;
    localparam int CKP_HAMMERS    = 18;
    localparam int CKP_HAM_FIRST  = 3;   // first hammer bit that maps onto column 0
    localparam int CKP_COL_MID    = 15;
    localparam int CKP_COL_HIGH   = 16;
    localparam int CKP_COL_W      = $clog2(CKP_PRINT_COLUMNS);
    localparam int CKP_CODE_W     = 6;
    localparam int CKP_DRUM_W     = 4;

    localparam logic [CKP_CODE_W-1:0] CKP_OFFSET_MID  = 6'd13;
    localparam logic [CKP_CODE_W-1:0] CKP_OFFSET_HIGH = 6'd26;

    typedef logic [CKP_CODE_W-1:0] t_cell;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  data;
        logic [39:0] key_lines;
        logic        paper_advance;
        logic [3:0]  row;
        logic [4:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [3:0] read_data;
        logic       test_level;
        logic [5:0] cell_code;
        logic       row_color;
    } t_out_item;

    // hammer state handed from the scan logic to the print store
    typedef struct packed {
        logic [CKP_HAMMERS-1:0] hammers;
        logic [CKP_DRUM_W-1:0]  drum;
    } t_ham_ctl;

endpackage

### rtl/calculator_keyboard_printer_io.sv
// ----------------------------------------------------------------------------
// calculator_keyboard_printer_io
// Keyboard scan and drum printer I/O of a desk calculator, one access per item.
//
//   channel  direction  handshake              payload
//   input    in         i_valid / o_stall      i_item   (t_in_item)
//   result   out        o_valid / i_stall      o_result (t_out_item)
//
// One item is taken every cycle while o_stall is low. An item waits in the input
// register, then all state updates and the result are formed in a single pass into the
// result register, from which the result is offered.
// Synchronous reset clears the shifters, drum, timer and the whole print store. A
// stalled result holds; the input register still fills behind it, and o_stall rises
// only when both registers are full.
// ----------------------------------------------------------------------------
module calculator_keyboard_printer_io
    import ckp_pkg::*;
#(
    parameter int PRINT_LINES = CKP_PRINT_LINES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_result
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      advance;
    logic      accept;
    t_ham_ctl  ham;
    logic [3:0] read_data;
    logic      test_level;
    logic [5:0] cell_code;
    logic      row_color;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    ckp_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_item       (r_in),
        .o_ham        (ham),
        .o_read_data  (read_data),
        .o_test_level (test_level)
    );

    ckp_print #(
        .PRINT_LINES (PRINT_LINES)
    ) u_print (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_item      (r_in),
        .i_ham       (ham),
        .o_cell_code (cell_code),
        .o_row_color (row_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;

            if (advance) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in <= i_item;
        if (advance) begin
            r_out.read_data  <= read_data;
            r_out.test_level <= test_level;
            r_out.cell_code  <= cell_code;
            r_out.row_color  <= row_color;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### rtl/ckp_scan.sv
// ----------------------------------------------------------------------------
// ckp_scan
// Keyboard and hammer shifters, timer phase, drum counter and nibble reads.
// ----------------------------------------------------------------------------
module ckp_scan
    import ckp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    output t_ham_ctl  o_ham,
    output logic [3:0] o_read_data,
    output logic      o_test_level
);

    logic [CKP_KEY_LINES-1:0] r_key, n_key;
    logic [CKP_HAMMERS-1:0]   r_ham, n_ham;
    logic [CKP_DRUM_W-1:0]    r_drum, n_drum;
    logic                     r_phase, n_phase;

    logic [3:0] key_line;
    logic       key_found;
    logic [CKP_DRUM_W-1:0] drum_inc;

    assign drum_inc = r_drum + 1'b1;

    always_comb begin
        n_key   = r_key;
        n_ham   = r_ham;
        n_drum  = r_drum;
        n_phase = r_phase;
        if (i_en) begin
            unique case (i_item.kind)
                KIND_SHIFT: begin
                    if (i_item.data[0]) n_key = {r_key[CKP_KEY_LINES-2:0], i_item.data[1]};
                    if (i_item.data[2]) n_ham = {r_ham[CKP_HAMMERS-2:0], i_item.data[1]};
                end
                KIND_TICK: begin
                    n_phase = ~r_phase;
                    // drum steps on the rising phase only
                    if (!r_phase) begin
                        if (32'(drum_inc) >= CKP_DRUM_STEPS) n_drum = '0;
                        else n_drum = drum_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // lowest zero bit of the column shifter picks the key line
    always_comb begin
        key_line  = '0;
        key_found = 1'b0;
        for (int i = 0; i < CKP_KEY_LINES; i++) begin
            if (!key_found && !r_key[i]) begin
                key_line  = 4'(i);
                key_found = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (i_item.kind)
            KIND_STATUS: o_read_data = {i_item.paper_advance, 2'b00, (r_drum == '0)};
            KIND_KEYS:   o_read_data = i_item.key_lines[{key_line, 2'b00} +: CKP_NIBBLE];
            default:     o_read_data = '0;
        endcase
    end

    assign o_test_level  = n_phase;
    assign o_ham.hammers = r_ham;
    assign o_ham.drum    = r_drum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_ham   <= '0;
            r_drum  <= '0;
            r_phase <= 1'b0;
        end else begin
            r_key   <= n_key;
            r_ham   <= n_ham;
            r_drum  <= n_drum;
            r_phase <= n_phase;
        end
    end

endmodule

### rtl/ckp_print.sv
// ----------------------------------------------------------------------------
// ckp_print
// Print store: line shift register of cells with red marks, hammer firing
// into the bottom line and a cell read port.
// ----------------------------------------------------------------------------
module ckp_print
    import ckp_pkg::*;
#(
    parameter int PRINT_LINES = CKP_PRINT_LINES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_in_item   i_item,
    input  t_ham_ctl   i_ham,
    output logic [5:0] o_cell_code,
    output logic       o_row_color
);

    localparam int BOTTOM = PRINT_LINES - 1;
    localparam int LW     = $clog2(PRINT_LINES);

    t_cell r_cells [PRINT_LINES][CKP_PRINT_COLUMNS];
    t_cell n_cells [PRINT_LINES][CKP_PRINT_COLUMNS];
    logic  [PRINT_LINES-1:0] r_red, n_red;

    t_cell code_low, code_mid, code_high;
    logic [LW-1:0]        row_idx;
    logic [CKP_COL_W-1:0] col_idx;
    logic                 in_range;

    assign code_low  = CKP_CODE_W'(i_ham.drum) + 1'b1;
    assign code_mid  = code_low + CKP_OFFSET_MID;
    assign code_high = code_low + CKP_OFFSET_HIGH;

    always_comb begin
        n_cells = r_cells;
        n_red   = r_red;
        if (i_en && i_item.kind == KIND_PRINT) begin
            if (i_item.data[0]) n_red[BOTTOM] = 1'b1;
            if (i_item.data[1]) begin
                for (int c = 0; c < CKP_COL_MID; c++) begin
                    if (i_ham.hammers[c + CKP_HAM_FIRST]) n_cells[BOTTOM][c] = code_low;
                end
                if (i_ham.hammers[0]) n_cells[BOTTOM][CKP_COL_MID]  = code_mid;
                if (i_ham.hammers[1]) n_cells[BOTTOM][CKP_COL_HIGH] = code_high;
            end
            // scroll after firing, so the fresh line moves up too
            if (i_item.data[3]) begin
                for (int l = 0; l < BOTTOM; l++) begin
                    n_cells[l] = n_cells[l + 1];
                    n_red[l]   = n_red[l + 1];
                end
                n_cells[BOTTOM] = '{default: '0};
                n_red[BOTTOM]   = 1'b0;
            end
        end
    end

    assign in_range = (32'(i_item.row) < PRINT_LINES)
                   && (32'(i_item.column) < CKP_PRINT_COLUMNS);
    assign row_idx  = LW'(i_item.row);
    assign col_idx  = CKP_COL_W'(i_item.column);

    always_comb begin
        o_cell_code = '0;
        o_row_color = 1'b0;
        if (i_item.kind == KIND_CELL && in_range) begin
            o_cell_code = r_cells[row_idx][col_idx];
            o_row_color = r_red[row_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= '{default: '{default: '0}};
            r_red   <= '0;
        end else begin
            r_cells <= n_cells;
            r_red   <= n_red;
        end
    end

endmodule

### test/ckp_io_checker.sv
// ----------------------------------------------------------------------------
// ckp_io_checker
// Watches both channels of the keyboard and printer I/O block. Keeps its own
// copy of the shifters, drum, timer and print store, works out the result of
// every access taken in, and compares each result sent out against the oldest
// one still outstanding.
// ----------------------------------------------------------------------------
module ckp_io_checker
    import ckp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_mismatches,
    output int        o_waiting,
    output int        o_checked
);

    // data bits of a shifter write
    localparam int SH_KEY_CLK = 0;
    localparam int SH_SERIAL  = 1;
    localparam int SH_HAM_CLK = 2;
    // data bits of a printer write
    localparam int PR_RED    = 0;
    localparam int PR_FIRE   = 1;
    localparam int PR_SCROLL = 3;

    localparam int BOTTOM = CKP_PRINT_LINES - 1;
    localparam int MAX_LINES_SHOWN = 40;

    logic [CKP_KEY_LINES-1:0] key_sr;
    logic [CKP_HAMMERS-1:0]   ham_sr;
    logic [CKP_DRUM_W-1:0]    drum;
    logic                     phase;
    t_cell                    cells [CKP_PRINT_LINES][CKP_PRINT_COLUMNS];
    logic                     red_line [CKP_PRINT_LINES];

    t_out_item access_results [$];
    t_out_item want;

    task automatic report_mismatch(input string what, input longint got, input longint wanted);
        if (o_mismatches < MAX_LINES_SHOWN) begin
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, wanted);
        end
        o_mismatches++;
    endtask

    function automatic t_out_item apply_access(input t_in_item it);
        t_out_item res;
        int line;
        res = '0;
        line = 0;
        case (it.kind)
            KIND_SHIFT: begin
                if (it.data[SH_KEY_CLK]) begin
                    key_sr = {key_sr[CKP_KEY_LINES-2:0], it.data[SH_SERIAL]};
                end
                if (it.data[SH_HAM_CLK]) begin
                    ham_sr = {ham_sr[CKP_HAMMERS-2:0], it.data[SH_SERIAL]};
                end
            end
            KIND_PRINT: begin
                if (it.data[PR_RED]) begin
                    red_line[BOTTOM] = 1'b1;
                end
                if (it.data[PR_FIRE]) begin
                    for (int h = CKP_HAM_FIRST; h < CKP_HAMMERS; h++) begin
                        if (ham_sr[h]) begin
                            cells[BOTTOM][h - CKP_HAM_FIRST] = {2'b00, drum} + 6'd1;
                        end
                    end
                    // the two low hammers print from the second and third drum sections
                    if (ham_sr[0]) begin
                        cells[BOTTOM][CKP_COL_MID] = {2'b00, drum} + CKP_OFFSET_MID + 6'd1;
                    end
                    if (ham_sr[1]) begin
                        cells[BOTTOM][CKP_COL_HIGH] = {2'b00, drum} + CKP_OFFSET_HIGH + 6'd1;
                    end
                end
                if (it.data[PR_SCROLL]) begin
                    for (int r = 0; r < BOTTOM; r++) begin
                        for (int c = 0; c < CKP_PRINT_COLUMNS; c++) begin
                            cells[r][c] = cells[r+1][c];
                        end
                        red_line[r] = red_line[r+1];
                    end
                    for (int c = 0; c < CKP_PRINT_COLUMNS; c++) begin
                        cells[BOTTOM][c] = '0;
                    end
                    red_line[BOTTOM] = 1'b0;
                end
            end
            KIND_TICK: begin
                phase = ~phase;
                if (phase) begin
                    drum = drum + 1'b1;
                end
                if (drum >= CKP_DRUM_STEPS) begin
                    drum = '0;
                end
            end
            KIND_STATUS: begin
                res.read_data = {it.paper_advance, 2'b00, drum == '0};
            end
            KIND_KEYS: begin
                // lowest zero column wins, line 0 when the shifter is all ones
                for (int i = CKP_KEY_LINES - 1; i >= 0; i--) begin
                    if (!key_sr[i]) begin
                        line = i;
                    end
                end
                res.read_data = it.key_lines[CKP_NIBBLE*line +: CKP_NIBBLE];
            end
            KIND_CELL: begin
                if (it.row < CKP_PRINT_LINES && it.column < CKP_PRINT_COLUMNS) begin
                    res.cell_code = cells[it.row][it.column];
                    res.row_color = red_line[it.row];
                end
            end
            default: begin
            end
        endcase
        res.test_level = phase;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_sr = '0;
            ham_sr = '0;
            drum   = '0;
            phase  = 1'b0;
            for (int r = 0; r < CKP_PRINT_LINES; r++) begin
                for (int c = 0; c < CKP_PRINT_COLUMNS; c++) begin
                    cells[r][c] = '0;
                end
                red_line[r] = 1'b0;
            end
            access_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
        end else begin
            // input transfer first so a same-edge result still finds its entry
            if (i_in_valid && !i_in_stall) begin
                access_results.push_back(apply_access(i_in_item));
            end
            if (i_out_valid && !i_out_stall) begin
                if (access_results.size() == 0) begin
                    report_mismatch("result count (none outstanding)", 1, 0);
                end else begin
                    want = access_results.pop_front();
                    if (i_out_item.read_data != want.read_data) begin
                        report_mismatch("read_data", i_out_item.read_data, want.read_data);
                    end
                    if (i_out_item.test_level != want.test_level) begin
                        report_mismatch("test_level", i_out_item.test_level, want.test_level);
                    end
                    if (i_out_item.cell_code != want.cell_code) begin
                        report_mismatch("cell_code", i_out_item.cell_code, want.cell_code);
                    end
                    if (i_out_item.row_color != want.row_color) begin
                        report_mismatch("row_color", i_out_item.row_color, want.row_color);
                    end
                end
                o_checked++;
            end
        end
        o_waiting = access_results.size();
    end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives keyboard shifts, printer writes, timer ticks and reads into the
// calculator keyboard and printer I/O block with random gaps and random
// result stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import ckp_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam logic [3:0] SHIFT_KEY   = 4'b0001;
    localparam logic [3:0] SHIFT_ONE   = 4'b0010;
    localparam logic [3:0] SHIFT_HAM   = 4'b0100;
    localparam logic [3:0] SHIFT_SPARE = 4'b1000;

    localparam logic [3:0] PRINT_RED    = 4'b0001;
    localparam logic [3:0] PRINT_FIRE   = 4'b0010;
    localparam logic [3:0] PRINT_SPARE  = 4'b0100;
    localparam logic [3:0] PRINT_SCROLL = 4'b1000;

    localparam int RANDOM_ACCESSES = 1675;
    localparam int QUIET_LIMIT     = 500;
    localparam int DRAIN_CYCLES    = 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    logic      idling_on = 1'b1;
    int        mismatches;
    int        waiting;
    int        checked;
    int        sent = 0;
    int        quiet_cycles = 0;

    t_in_item    it;
    logic [63:0] wide;
    int          pick;

    calculator_keyboard_printer_io u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_valid  (in_valid),
        .o_stall  (in_stall),
        .i_item   (in_item),
        .o_valid  (out_valid),
        .i_stall  (out_stall),
        .o_result (out_item)
    );

    ckp_io_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= rst_n && idling_on && ($urandom_range(99) < 36);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d cycles without a transfer, %0d results outstanding",
                     quiet_cycles, waiting);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_in_item pack_access(input logic [2:0] kind, input logic [3:0] data,
                                             input logic [39:0] keys, input logic paper,
                                             input logic [3:0] row, input logic [4:0] column);
        t_in_item a;
        a.kind          = kind;
        a.data          = data;
        a.key_lines     = keys;
        a.paper_advance = paper;
        a.row           = row;
        a.column        = column;
        return a;
    endfunction

    // holds valid and payload until the transfer happens
    task automatic send_access(input t_in_item a);
        @(negedge clk);
        while (idling_on && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= a;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fresh state: drum at zero, empty shifter picks line 0, blank store
        send_access(pack_access(KIND_STATUS, 4'hf, '1, 1'b1, 4'd0, 5'd0));
        send_access(pack_access(KIND_KEYS, 4'h0, 40'h0123456789, 1'b0, 4'd0, 5'd0));
        send_access(pack_access(KIND_CELL, 4'h0, '0, 1'b0, 4'd10, 5'd16));
        // fill key shifter with ones, hammers get bits 0..9
        repeat (10) begin
            send_access(pack_access(KIND_SHIFT, SHIFT_KEY | SHIFT_ONE | SHIFT_HAM | SHIFT_SPARE,
                                    '0, 1'b0, 4'd0, 5'd0));
        end
        // no zero column left, so line 0 again
        send_access(pack_access(KIND_KEYS, 4'h0, 40'hfedcba9876, 1'b1, 4'd15, 5'd31));
        send_access(pack_access(KIND_PRINT, PRINT_RED | PRINT_FIRE | PRINT_SPARE,
                                '0, 1'b0, 4'd0, 5'd0));
        send_access(pack_access(KIND_CELL, 4'h0, '0, 1'b0, 4'd10, 5'd0));
        send_access(pack_access(KIND_CELL, 4'h0, '0, 1'b0, 4'd10, 5'd15));
        send_access(pack_access(KIND_CELL, 4'h0, '0, 1'b0, 4'd10, 5'd16));
        send_access(pack_access(KIND_TICK, 4'h0, '0, 1'b0, 4'd0, 5'd0));
        send_access(pack_access(KIND_PRINT, PRINT_RED | PRINT_FIRE | PRINT_SPARE | PRINT_SCROLL,
                                '0, 1'b0, 4'd0, 5'd0));
        send_access(pack_access(KIND_CELL, 4'h0, '0, 1'b0, 4'd9, 5'd16));
        send_access(pack_access(KIND_CELL, 4'h0, '0, 1'b0, 4'd10, 5'd0));
        // beyond the store on both axes
        send_access(pack_access(KIND_CELL, 4'hf, '1, 1'b1, 4'd15, 5'd31));
        send_access(pack_access(KIND_SPARE_LO, 4'hf, '1, 1'b1, 4'd9, 5'd0));
        send_access(pack_access(KIND_SPARE_HI, 4'hf, '1, 1'b1, 4'd9, 5'd0));
        send_access(pack_access(KIND_STATUS, 4'h0, '0, 1'b0, 4'd0, 5'd0));

        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            idling_on = !(n >= 700 && n < 1000);
            if (n % 400 == 0) begin
                wait_for_drain();
            end
            wide = {$urandom, $urandom};
            it.key_lines     = wide[39:0];
            it.paper_advance = 1'($urandom_range(1));
            it.data          = 4'($urandom_range(15));
            it.row           = 4'($urandom_range(15));
            it.column        = 5'($urandom_range(31));
            pick = int'($urandom_range(99));
            if (pick < 30) begin
                // mostly ones keep long runs in the key shifter
                it.kind = KIND_SHIFT;
                if ($urandom_range(3) != 0) begin
                    it.data = it.data | SHIFT_ONE;
                end
            end else if (pick < 42) begin
                it.kind = KIND_PRINT;
                if ($urandom_range(2) != 0) begin
                    it.data = it.data & ~PRINT_SCROLL;
                end
            end else if (pick < 62) begin
                it.kind = KIND_TICK;
            end else if (pick < 70) begin
                it.kind = KIND_STATUS;
            end else if (pick < 80) begin
                it.kind = KIND_KEYS;
            end else if (pick < 96) begin
                it.kind = KIND_CELL;
                if ($urandom_range(7) != 0) begin
                    it.row    = 4'($urandom_range(CKP_PRINT_LINES - 1));
                    it.column = 5'($urandom_range(CKP_PRINT_COLUMNS - 1));
                end
            end else begin
                it.kind = $urandom_range(1) ? KIND_SPARE_LO : KIND_SPARE_HI;
            end
            send_access(it);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d accesses driven: shifts, prints, ticks, reads, off-store cells, spare kinds",
                 sent);
        $display("%0d results compared, %0d field mismatches", checked, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
